[src/tccw_pkg.sv]
`default_nettype none

package tccw_pkg;

   // default screen geometry
   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // interpreted control characters
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_BLANK = 8'h20;

   localparam logic [7:0]  RESET_ATTR  = 8'h07;
   localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CHAR_BLANK};

   typedef struct packed {
      logic [15:0] cell_value;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_position;
      logic        scrolled;
   } result_type;

endpackage

`default_nettype wire

[src/tccw_cell_mem.sv]
`default_nettype none

module tccw_cell_mem #(
   parameter int CELLS = tccw_pkg::DEFAULT_COLUMNS * tccw_pkg::DEFAULT_ROWS,
   parameter int AW    = $clog2(CELLS)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [15:0]   wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [15:0]   rdata
);

   logic [15:0] cells [CELLS];
   logic [15:0] rdata_ff;

   // one write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (we) begin
         cells[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= cells[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/tccw_ctrl.sv]
`default_nettype none

module tccw_ctrl #(
   parameter int COLUMNS = tccw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tccw_pkg::DEFAULT_ROWS,
   parameter int AW      = $clog2(COLUMNS * ROWS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_operation,
   input  wire logic [7:0]            req_char_code,
   input  wire logic [10:0]           req_cell_index,
   input  wire logic [7:0]            attr,
   input  wire logic                  rsp_free,
   output logic                       done,
   output tccw_pkg::result_type       result,
   output logic                       mem_we,
   output logic [AW-1:0]              mem_waddr,
   output logic [15:0]                mem_wdata,
   output logic                       mem_re,
   output logic [AW-1:0]              mem_raddr,
   input  wire logic [15:0]           mem_rdata
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CW  = $clog2(COLUMNS);
   localparam int RW  = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam int KW  = $clog2(CELL_COUNT + 1);
   localparam int CXW = (CW > 7) ? CW : 7;
   localparam int RXW = (RW > 5) ? RW : 5;
   localparam int PXW = (AW > 11) ? AW : 11;

   localparam logic [CW:0]   COL_LIMIT  = (CW+1)'(COLUMNS);
   localparam logic [RW:0]   ROW_LIMIT  = (RW+1)'(ROWS);
   localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
   localparam logic [AW-1:0] LAST_BASE  = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
   localparam logic [KW-1:0] SCAN_FIRST = KW'(COLUMNS);
   localparam logic [KW-1:0] SCAN_END   = KW'(CELL_COUNT);
   localparam logic [KW-1:0] FILL_LAST  = KW'(CELL_COUNT - 1);
   localparam logic [KW-1:0] TAIL_FIRST = KW'(CELL_COUNT - COLUMNS);
   localparam logic [KW-1:0] COPY_LAG   = KW'(COLUMNS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCROLL = 3'd2;
   localparam logic [2:0] S_FILL   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] base_ff, base_in;
   logic [KW-1:0] scan_ff, scan_in;
   logic [15:0]   fill_cell_ff, fill_cell_in;
   logic          fill_done_ff, fill_done_in;
   logic          scrolled_ff, scrolled_in;
   logic          hit_ff, hit_in;
   logic [1:0]    op_ff, op_in;
   logic [7:0]    char_ff, char_in;
   logic [10:0]   idx_ff, idx_in;

   // write decode
   logic [CW:0]   col_x, col_sum, col_t;
   logic [RW:0]   row_t;
   logic          row_step, wr_en, scroll_hit;
   logic [AW-1:0] cell_addr, wr_addr, base_t;
   logic [15:0]   wr_data;
   logic [KW-1:0] copy_addr;
   logic          idx_ok;
   logic [AW-1:0] pos;
   logic [CXW-1:0] col_out;
   logic [RXW-1:0] row_out;
   logic [PXW-1:0] pos_out;

   always_comb begin
      col_x     = {1'b0, col_ff};
      col_sum   = col_x + (CW+1)'(4);
      cell_addr = base_ff + AW'(col_ff);
      col_t     = col_x;
      row_step  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = cell_addr;
      wr_data   = {attr, char_ff};
      unique case (char_ff)
         tccw_pkg::CHAR_LF: begin
            col_t    = '0;
            row_step = 1'b1;
         end
         tccw_pkg::CHAR_CR: begin
            col_t = '0;
         end
         tccw_pkg::CHAR_TAB: begin
            col_t = {col_sum[CW:2], 2'b00};
         end
         tccw_pkg::CHAR_BS: begin
            if (col_ff != '0) begin
               col_t   = col_x - (CW+1)'(1);
               wr_en   = 1'b1;
               wr_addr = cell_addr - AW'(1);
               wr_data = {attr, tccw_pkg::CHAR_BLANK};
            end
         end
         default: begin
            wr_en = 1'b1;
            col_t = col_x + (CW+1)'(1);
         end
      endcase
      // wrap past the right edge
      if (col_t >= COL_LIMIT) begin
         col_t    = '0;
         row_step = 1'b1;
      end
      row_t      = {1'b0, row_ff} + (RW+1)'(row_step);
      scroll_hit = row_t >= ROW_LIMIT;
      base_t     = row_step ? base_ff + ROW_STRIDE : base_ff;
   end

   assign copy_addr = scan_ff - COPY_LAG;
   assign idx_ok    = 32'(idx_ff) < 32'(CELL_COUNT);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      scan_in      = scan_ff;
      fill_cell_in = fill_cell_ff;
      fill_done_in = fill_done_ff;
      scrolled_in  = scrolled_ff;
      hit_in       = hit_ff;
      op_in        = op_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_operation;
               char_in     = req_char_code;
               idx_in      = req_cell_index;
               scrolled_in = 1'b0;
               hit_in      = 1'b0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               tccw_pkg::OP_WRITE: begin
                  mem_we    = wr_en;
                  mem_waddr = wr_addr;
                  mem_wdata = wr_data;
                  col_in    = col_t[CW-1:0];
                  if (scroll_hit) begin
                     row_in       = LAST_ROW;
                     base_in      = LAST_BASE;
                     scan_in      = SCAN_FIRST;
                     fill_cell_in = {attr, tccw_pkg::CHAR_BLANK};
                     fill_done_in = 1'b1;
                     scrolled_in  = 1'b1;
                     state_in     = S_SCROLL;
                  end else begin
                     row_in   = row_t[RW-1:0];
                     base_in  = base_t;
                     state_in = S_DONE;
                  end
               end
               tccw_pkg::OP_READ: begin
                  mem_re    = idx_ok;
                  mem_raddr = AW'(idx_ff);
                  hit_in    = idx_ok;
                  state_in  = S_DONE;
               end
               tccw_pkg::OP_CLEAR: begin
                  col_in       = '0;
                  row_in       = '0;
                  base_in      = '0;
                  scan_in      = '0;
                  fill_cell_in = {attr, tccw_pkg::CHAR_BLANK};
                  fill_done_in = 1'b1;
                  state_in     = S_FILL;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCROLL: begin
            // read one row ahead, write the previous read one row up
            mem_re    = scan_ff != SCAN_END;
            mem_raddr = scan_ff[AW-1:0];
            mem_we    = scan_ff != SCAN_FIRST;
            mem_waddr = copy_addr[AW-1:0];
            mem_wdata = mem_rdata;
            if (scan_ff == SCAN_END) begin
               scan_in  = TAIL_FIRST;
               state_in = S_FILL;
            end else begin
               scan_in = scan_ff + KW'(1);
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[AW-1:0];
            mem_wdata = fill_cell_ff;
            if (scan_ff == FILL_LAST) begin
               state_in = fill_done_ff ? S_DONE : S_IDLE;
            end else begin
               scan_in = scan_ff + KW'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         scan_ff      <= '0;
         fill_cell_ff <= tccw_pkg::RESET_BLANK;
         fill_done_ff <= 1'b0;
         scrolled_ff  <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         scan_ff      <= scan_in;
         fill_cell_ff <= fill_cell_in;
         fill_done_ff <= fill_done_in;
         scrolled_ff  <= scrolled_in;
         hit_ff       <= hit_in;
      end
      op_ff   <= op_in;
      char_ff <= char_in;
      idx_ff  <= idx_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign done      = state_ff == S_DONE;

   assign pos     = base_ff + AW'(col_ff);
   assign col_out = CXW'(col_ff);
   assign row_out = RXW'(row_ff);
   assign pos_out = PXW'(pos);

   always_comb begin
      result.cell_value      = hit_ff ? mem_rdata : 16'h0000;
      result.cursor_column   = col_out[6:0];
      result.cursor_row      = row_out[4:0];
      result.cursor_position = pos_out[10:0];
      result.scrolled        = scrolled_ff;
   end

   // copy and fill never touch the entry being read
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
      else $error("read and write address clash");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor out of range");

   a_base_tracks_row: assert property (@(posedge clock) disable iff (reset)
      base_ff == AW'(32'(row_ff) * COLUMNS))
      else $error("row base out of step with row");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_free) |=> (state_ff == S_IDLE))
      else $error("result handed over but engine not idle");

endmodule

`default_nettype wire

[src/text_console_character_writer.sv]
// text console character writer
// req channel: one item = operation, char_code, cell_index; taken when
//   req_valid is high and req_stall is low. operation 0 writes a character at
//   the cursor (line feed, carriage return, tab and backspace move the
//   cursor), 1 reads one cell, 2 clears the screen and homes the cursor.
// rsp channel: exactly one item per request, in order; cell_value carries the
//   cell for a read within the store and 0 otherwise, plus the cursor after
//   the operation and a flag when a write scrolled the screen.
// csr channel: csr_text_attribute is taken when csr_valid and csr_ready are
//   both high; it is the attribute byte for written and blanked cells. write
//   it only while no item is in flight.
// sequencing: a plain write, read or cursor move passes through the store
//   access and the result register before rsp_valid rises; the next request is
//   taken only once the engine is back in idle. a scroll first copies each cell
//   below the top row up one row through the single read and write port of
//   the cell store, then blanks the last row; a clear writes blanks to every cell.
// reset: the cursor goes home, the attribute to 0x07, and the store is
//   swept to blanks with req_stall held high.
// a stalled rsp holds its item; the next request is still taken meanwhile and
//   its result waits in the engine until the output register frees up
`default_nettype none

module text_console_character_writer #(
   parameter int COLUMNS = tccw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tccw_pkg::DEFAULT_ROWS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [10:0] req_cell_index,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_cell_value,
   output logic [6:0]       rsp_cursor_column,
   output logic [4:0]       rsp_cursor_row,
   output logic [10:0]      rsp_cursor_position,
   output logic             rsp_scrolled,
   // attribute register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_text_attribute
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   // attribute register
   logic [7:0] attr_ff, attr_in;

   // output register between the engine and the rsp side
   logic                 rsp_valid_ff, rsp_valid_in;
   tccw_pkg::result_type rsp_ff, rsp_in;

   logic                 done;
   logic                 rsp_free;
   logic                 rsp_load;
   tccw_pkg::result_type result;

   // cell store port
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [15:0]   mem_rdata;

   // the register is always ready to take a write
   assign csr_ready = 1'b1;
   assign attr_in   = (csr_valid && csr_ready) ? csr_text_attribute : attr_ff;

   // the output slot is free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = done && rsp_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tccw_pkg::RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload only
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_ff.cell_value;
   assign rsp_cursor_column   = rsp_ff.cursor_column;
   assign rsp_cursor_row      = rsp_ff.cursor_row;
   assign rsp_cursor_position = rsp_ff.cursor_position;
   assign rsp_scrolled        = rsp_ff.scrolled;

   // cursor, decode and store sequencing
   tccw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .attr           (attr_ff),
      .rsp_free       (rsp_free),
      .done           (done),
      .result         (result),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_re         (mem_re),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   // character cell store
   tccw_cell_mem #(
      .CELLS (CELLS),
      .AW    (AW)
   ) u_cell_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

[verif/text_console_character_writer_checker.sv]
`default_nettype none

module text_console_character_writer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [10:0] req_cell_index,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [15:0] rsp_cell_value,
   input  wire logic [6:0]  rsp_cursor_column,
   input  wire logic [4:0]  rsp_cursor_row,
   input  wire logic [10:0] rsp_cursor_position,
   input  wire logic        rsp_scrolled,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [7:0]  csr_text_attribute,
   output int               mismatch_count,
   output int               awaited_count,
   output int               checked_count,
   output int               scroll_count
);

   localparam int COLS        = tccw_pkg::DEFAULT_COLUMNS;
   localparam int LINES       = tccw_pkg::DEFAULT_ROWS;
   localparam int CELLS       = COLS * LINES;
   localparam int PRINT_LIMIT = 100;

   logic [15:0]          screen_mirror [CELLS];
   int                   mirror_column;
   int                   mirror_row;
   logic [7:0]           mirror_attribute;
   tccw_pkg::result_type awaited_results [$];

   function automatic void blank_cells(input int first, input int last);
      for (int i = first; i < last; i++) begin
         screen_mirror[i] = {mirror_attribute, tccw_pkg::CHAR_BLANK};
      end
   endfunction

   // moves the mirrored console on by one request and returns its response
   function automatic tccw_pkg::result_type apply_console_request(
      input logic [1:0]  op,
      input logic [7:0]  ch,
      input logic [10:0] idx);
      tccw_pkg::result_type outcome;
      int                   linear;
      outcome = '0;
      case (op)
         tccw_pkg::OP_WRITE: begin
            if (ch == tccw_pkg::CHAR_LF) begin
               mirror_column = 0;
               mirror_row++;
            end else if (ch == tccw_pkg::CHAR_CR) begin
               mirror_column = 0;
            end else if (ch == tccw_pkg::CHAR_TAB) begin
               mirror_column = (mirror_column + 4) & ~3;
            end else if (ch == tccw_pkg::CHAR_BS) begin
               if (mirror_column > 0) begin
                  mirror_column--;
                  screen_mirror[mirror_row * COLS + mirror_column] =
                     {mirror_attribute, tccw_pkg::CHAR_BLANK};
               end
            end else begin
               screen_mirror[mirror_row * COLS + mirror_column] = {mirror_attribute, ch};
               mirror_column++;
            end
            if (mirror_column >= COLS) begin
               mirror_column = 0;
               mirror_row++;
            end
            if (mirror_row >= LINES) begin
               for (int i = 0; i < CELLS - COLS; i++) begin
                  screen_mirror[i] = screen_mirror[i + COLS];
               end
               blank_cells(CELLS - COLS, CELLS);
               mirror_row       = LINES - 1;
               outcome.scrolled = 1'b1;
            end
         end
         tccw_pkg::OP_READ: begin
            if (idx < CELLS) begin
               outcome.cell_value = screen_mirror[idx];
            end
         end
         tccw_pkg::OP_CLEAR: begin
            blank_cells(0, CELLS);
            mirror_column = 0;
            mirror_row    = 0;
         end
         default: ;
      endcase
      linear                  = mirror_row * COLS + mirror_column;
      outcome.cursor_column   = mirror_column[6:0];
      outcome.cursor_row      = mirror_row[4:0];
      outcome.cursor_position = linear[10:0];
      return outcome;
   endfunction

   task automatic report_mismatch(input string detail);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch: %s", detail);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      tccw_pkg::result_type expected_item;
      if (reset) begin
         mirror_attribute = tccw_pkg::RESET_ATTR;
         blank_cells(0, CELLS);
         mirror_column = 0;
         mirror_row    = 0;
         awaited_results.delete();
         mismatch_count = 0;
         awaited_count  = 0;
         checked_count  = 0;
         scroll_count   = 0;
      end else begin
         // responses first, so a stray one never pairs with a request taken this edge
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            checked_count++;
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing expected",
                                         checked_count));
            end else begin
               expected_item = awaited_results.pop_front();
               if (rsp_cell_value !== expected_item.cell_value)
                  report_mismatch($sformatf("response %0d cell_value 0x%h, expected 0x%h",
                     checked_count, rsp_cell_value, expected_item.cell_value));
               if (rsp_cursor_column !== expected_item.cursor_column)
                  report_mismatch($sformatf("response %0d cursor_column %0d, expected %0d",
                     checked_count, rsp_cursor_column, expected_item.cursor_column));
               if (rsp_cursor_row !== expected_item.cursor_row)
                  report_mismatch($sformatf("response %0d cursor_row %0d, expected %0d",
                     checked_count, rsp_cursor_row, expected_item.cursor_row));
               if (rsp_cursor_position !== expected_item.cursor_position)
                  report_mismatch($sformatf("response %0d cursor_position %0d, expected %0d",
                     checked_count, rsp_cursor_position, expected_item.cursor_position));
               if (rsp_scrolled !== expected_item.scrolled)
                  report_mismatch($sformatf("response %0d scrolled %b, expected %b",
                     checked_count, rsp_scrolled, expected_item.scrolled));
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            mirror_attribute = csr_text_attribute;
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            expected_item = apply_console_request(req_operation, req_char_code,
                                                  req_cell_index);
            if (expected_item.scrolled) begin
               scroll_count++;
            end
            awaited_results.push_back(expected_item);
         end
         awaited_count = awaited_results.size();
      end
   end

endmodule

`default_nettype wire

[verif/text_console_character_writer_test.sv]
`default_nettype none

module text_console_character_writer_test;

   // the block has no name for the spare operation code
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // items per random phase and the number of attribute phases
   localparam int PHASE_ITEMS = 250;
   localparam int PHASES      = 8;

   // a typical run goes mostly to scroll and clear sweeps; LIMIT_TIME caps the run
   localparam int LIMIT_TIME = 320_000_000;

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation       = tccw_pkg::OP_WRITE;
   logic [7:0]  req_char_code       = 8'h00;
   logic [10:0] req_cell_index      = 11'd0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic [15:0] rsp_cell_value;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic [10:0] rsp_cursor_position;
   logic        rsp_scrolled;
   logic        csr_valid           = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_text_attribute  = 8'h00;

   int mismatch_count;
   int awaited_count;
   int checked_count;
   int scroll_count;

   // stimulus tallies for the closing summary
   int request_total = 0;
   int write_total   = 0;
   int read_total    = 0;
   int clear_total   = 0;
   int unused_total  = 0;
   int attr_total    = 0;

   // when set, neither side idles
   bit calm = 1'b0;

   always #4 clock = ~clock;

   text_console_character_writer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_text_attribute  (csr_text_attribute)
   );

   text_console_character_writer_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_text_attribute  (csr_text_attribute),
      .mismatch_count      (mismatch_count),
      .awaited_count       (awaited_count),
      .checked_count       (checked_count),
      .scroll_count        (scroll_count)
   );

   // receiver back-pressure, roughly a quarter of cycles unless calm
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
   end

   // one request item: optional idle cycles, then hold it until taken
   task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                               input logic [10:0] idx);
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_char_code  <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      case (op)
         tccw_pkg::OP_WRITE: write_total++;
         tccw_pkg::OP_READ:  read_total++;
         tccw_pkg::OP_CLEAR: clear_total++;
         default:            unused_total++;
      endcase
      // the spare code is ignored by the block, so it does not count
      if (op != OP_UNUSED) begin
         request_total++;
      end
   endtask

   // sender holds off until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_count != 0);
   endtask

   // attribute register write, only ever issued with nothing in flight
   task automatic write_attribute(input logic [7:0] shade);
      csr_valid          <= 1'b1;
      csr_text_attribute <= shade;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      attr_total++;
   endtask

   // one random step: mostly character writes, some reads, rare clears,
   // the odd spare code and now and then a long run of text that wraps
   task automatic issue_random_request();
      int          pick;
      int          run_length;
      logic [7:0]  glyph;
      logic [10:0] spot;
      pick = $urandom_range(0, 999);
      if (pick < 5) begin
         send_request(tccw_pkg::OP_CLEAR, 8'($urandom), 11'($urandom));
      end else if (pick < 15) begin
         send_request(OP_UNUSED, 8'($urandom), 11'($urandom));
      end else if (pick < 170) begin
         // a few reads land past the end of the store
         if ($urandom_range(0, 19) == 0) begin
            spot = 11'($urandom_range(2000, 2047));
         end else begin
            spot = 11'($urandom_range(0, 1999));
         end
         send_request(tccw_pkg::OP_READ, 8'($urandom), spot);
      end else if (pick >= 995) begin
         // a line of text, often long enough to wrap, then a line feed
         run_length = $urandom_range(60, 100);
         repeat (run_length) begin
            send_request(tccw_pkg::OP_WRITE, 8'($urandom_range(8'h20, 8'h7E)),
                         11'($urandom));
         end
         send_request(tccw_pkg::OP_WRITE, tccw_pkg::CHAR_LF, 11'($urandom));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 7) begin
            glyph = tccw_pkg::CHAR_LF;
         end else if (pick < 10) begin
            glyph = tccw_pkg::CHAR_CR;
         end else if (pick < 15) begin
            glyph = tccw_pkg::CHAR_TAB;
         end else if (pick < 21) begin
            glyph = tccw_pkg::CHAR_BS;
         end else if (pick < 85) begin
            glyph = 8'($urandom_range(8'h20, 8'h7E));
         end else begin
            glyph = 8'($urandom);
         end
         send_request(tccw_pkg::OP_WRITE, glyph, 11'($urandom));
      end
   endtask

   initial begin : stimulus
      int         phase_start;
      logic [7:0] shade;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: store contents straight after reset, reset attribute
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd0);
      send_request(tccw_pkg::OP_READ, 8'hFF, 11'd1999);
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd2000);   // just past the store
      send_request(tccw_pkg::OP_READ, 8'h00, 11'h7FF);    // widest index
      send_request(tccw_pkg::OP_WRITE, 8'h41, 11'd0);
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd0);
      send_request(OP_UNUSED, 8'hFF, 11'h7FF);            // spare code does nothing
      send_request(tccw_pkg::OP_WRITE, tccw_pkg::CHAR_BS, 11'd0);  // back over the letter
      send_request(tccw_pkg::OP_WRITE, tccw_pkg::CHAR_BS, 11'd0);  // at column 0, no effect
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd0);

      // directed: control codes and extreme bytes with a full attribute
      wait_drained();
      write_attribute(8'hFF);
      send_request(tccw_pkg::OP_WRITE, 8'h00, 11'd0);
      send_request(tccw_pkg::OP_WRITE, 8'hFF, 11'h7FF);
      send_request(tccw_pkg::OP_WRITE, tccw_pkg::CHAR_TAB, 11'd0); // column 2 rounds up to 4
      send_request(tccw_pkg::OP_WRITE, tccw_pkg::CHAR_TAB, 11'd0); // exact multiple moves on
      send_request(tccw_pkg::OP_WRITE, tccw_pkg::CHAR_CR, 11'd0);
      send_request(tccw_pkg::OP_WRITE, tccw_pkg::CHAR_LF, 11'd0);
      send_request(tccw_pkg::OP_WRITE, 8'h7E, 11'h7FF);
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd0);
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd1);
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd80);
      send_request(tccw_pkg::OP_CLEAR, 8'hFF, 11'h7FF);
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd1);

      // directed: zero attribute
      wait_drained();
      write_attribute(8'h00);
      send_request(tccw_pkg::OP_WRITE, 8'h5A, 11'd0);
      send_request(tccw_pkg::OP_READ, 8'h00, 11'd0);

      // random phases, each under its own attribute; the extremes come first
      // and the middle phase runs with no idling on either side
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0:       shade = 8'h00;
            1:       shade = 8'hFF;
            default: shade = 8'($urandom);
         endcase
         write_attribute(shade);
         calm = (phase == 3);
         phase_start = request_total;
         while (request_total - phase_start < PHASE_ITEMS) begin
            issue_random_request();
         end
      end
      calm = 1'b0;

      // let the last responses come home, then a short tail for strays
      wait_drained();
      repeat (30) @(negedge clock);

      $display("covered %0d requests: %0d writes, %0d reads, %0d clears, %0d spare codes",
               request_total, write_total, read_total, clear_total, unused_total);
      $display("%0d attribute settings, %0d responses checked, %0d screen scrolls",
               attr_total, checked_count, scroll_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #LIMIT_TIME;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
